// ===== sv/qfbr_pkg.sv =====
// Package: store geometry, command codes and byte-order helper for the bit reader.
`timescale 1ns / 1ps
`default_nettype none
package qfbr_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int SLOT_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int POS_W      = 7;
    localparam int LIMIT_W    = CNT_W + POS_W;
    localparam int MAX_BITS   = 32;

    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_PEEK    = 3'd1;
    localparam logic [2:0] CMD_ADVANCE = 3'd2;
    localparam logic [2:0] CMD_ALIGN   = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;

    typedef logic [2:0]  cmd_t;
    typedef logic [63:0] half_t;
    typedef logic [31:0] value_t;
    typedef logic [5:0]  count_t;
    typedef logic [7:0]  adv_t;
    typedef logic [3:0]  fill_t;

    // Stream byte 0 sits in bits 7:0; swap so the stream reads MSB first.
    function automatic half_t byte_swap(input half_t w);
        half_t r;
        for (int k = 0; k < 8; k++)
        begin
            r[63 - 8*k -: 8] = w[8*k +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/qfbr_in_if.sv =====
// Interface: command channel of the bit reader.
`timescale 1ns / 1ps
`default_nettype none
interface qfbr_in_if;
    import qfbr_pkg::*;

    logic   valid;
    logic   ready;
    cmd_t   cmd;
    half_t  push_upper;
    half_t  push_lower;
    count_t bit_count;
    adv_t   advance_by;

    modport source (output valid, cmd, push_upper, push_lower, bit_count, advance_by,
                    input ready);
    modport sink   (input valid, cmd, push_upper, push_lower, bit_count, advance_by,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/qfbr_out_if.sv =====
// Interface: result channel of the bit reader.
`timescale 1ns / 1ps
`default_nettype none
interface qfbr_out_if;
    import qfbr_pkg::*;

    logic   valid;
    logic   ready;
    value_t peek_value;
    logic   ok;
    fill_t  fill_level;

    modport source (output valid, peek_value, ok, fill_level, input ready);
    modport sink   (input valid, peek_value, ok, fill_level, output ready);
endinterface
`default_nettype wire

// ===== sv/quadword_fifo_bit_reader_core.sv =====
// Top level: big-endian bit reader over a FIFO of 128-bit quadwords.
// Timing: push, advance, align, flush and unknown codes give their result word
//   in the cycle after acceptance; peek first passes through ST_PEEK, then its result is registered.
// Throughput: one word per cycle for all commands but peek while the reply is taken; a
//   peek holds off the next command while it waits on the registered read of the quadword store.
// Reset: rst_n clears pointer, head, count and the output valid at once; the
//   store itself is not cleared, only pushed slots are ever read.
`timescale 1ns / 1ps
`default_nettype none
module quadword_fifo_bit_reader_core (
    input  wire logic clk,
    input  wire logic rst_n,
    qfbr_in_if.sink   req,
    qfbr_out_if.source rsp
);
    import qfbr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PEEK = 1'b1;

    // Control state
    logic                state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    count_t              cnt_reg, cnt_next;
    value_t              value_reg, value_next;
    logic                ok_reg, ok_next;
    fill_t               fill_reg, fill_next;

    // Store: lower halves in one RAM, upper halves in the other, one slot per address
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_slot;
    logic [SLOT_W-1:0]   lower_rd_slot;
    half_t               lower_rd;
    half_t               upper_rd;

    logic                accept;
    logic                full;
    logic [SLOT_W-1:0]   head_inc;
    logic [SLOT_W:0]     tail_sum;
    logic [LIMIT_W-1:0]  limit;

    // Advance datapath, shared by advance and byte align
    logic [2:0]          frac;
    logic [5:0]          adv_amt;
    logic [LIMIT_W-1:0]  adv_sum;
    logic                adv_fit;

    // Peek datapath
    logic [LIMIT_W-1:0]  peek_end;
    logic                peek_ok;
    half_t               w0;
    half_t               w1;
    logic [127:0]        window;
    logic [127:0]        shifted;
    value_t              peek_bits;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid      = out_valid_reg;
    assign rsp.peek_value = value_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.fill_level = fill_reg;

    assign full     = (held_reg == CNT_W'(FIFO_DEPTH));
    assign head_inc = (head_reg == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign tail_sum = (SLOT_W+1)'(head_reg) + (SLOT_W+1)'(held_reg);
    assign wr_slot  = (tail_sum >= (SLOT_W+1)'(FIFO_DEPTH))
                      ? SLOT_W'(tail_sum - (SLOT_W+1)'(FIFO_DEPTH))
                      : SLOT_W'(tail_sum);
    assign wr_en    = accept && (req.cmd == CMD_PUSH) && !full;
    assign limit    = {held_reg, {POS_W{1'b0}}};

    // Bits past the lower half of the head continue in its upper half, and
    // bits past the upper half continue in the lower half of the next slot.
    assign lower_rd_slot = pos_reg[6] ? head_inc : head_reg;

    qfbr_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_lower_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (req.push_lower),
        .rd_addr (lower_rd_slot),
        .rd_data (lower_rd)
    );

    qfbr_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_upper_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (req.push_upper),
        .rd_addr (head_reg),
        .rd_data (upper_rd)
    );

    // Advance amount: clamped count, or the distance to the next byte boundary
    assign frac = pos_reg[2:0];
    always_comb
    begin
        if (req.cmd == CMD_ALIGN)
        begin
            adv_amt = (frac != 3'd0) ? (6'd8 - 6'(frac)) : 6'd0;
        end
        else
        begin
            adv_amt = (req.advance_by > 8'(MAX_BITS)) ? 6'(MAX_BITS) : req.advance_by[5:0];
        end
    end
    assign adv_sum = LIMIT_W'(pos_reg) + LIMIT_W'(adv_amt);
    assign adv_fit = (adv_sum <= limit);

    // Peek: pointer state is unchanged since acceptance, read data now valid
    assign peek_end  = LIMIT_W'(pos_reg) + LIMIT_W'(cnt_reg);
    assign peek_ok   = (cnt_reg != 6'd0) && (cnt_reg <= 6'(MAX_BITS)) && (peek_end <= limit);
    assign w0        = pos_reg[6] ? upper_rd : lower_rd;
    assign w1        = pos_reg[6] ? lower_rd : upper_rd;
    assign window    = {byte_swap(w0), byte_swap(w1)};
    assign shifted   = window << pos_reg[5:0];
    assign peek_bits = shifted[127:96] >> (6'(MAX_BITS) - cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        ok_next        = ok_reg;
        fill_next      = fill_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    logic ok_c;
                    ok_c = 1'b0;
                    unique case (req.cmd)
                        CMD_PUSH:
                        begin
                            if (!full)
                            begin
                                held_next = held_reg + CNT_W'(1);
                                ok_c      = 1'b1;
                            end
                        end
                        CMD_PEEK:
                        begin
                            state_next = ST_PEEK;
                            cnt_next   = req.bit_count;
                        end
                        CMD_ADVANCE, CMD_ALIGN:
                        begin
                            if (adv_fit)
                            begin
                                pos_next = adv_sum[POS_W-1:0];
                                // Crossing 128 bits retires the head quadword
                                if (adv_sum[POS_W])
                                begin
                                    head_next = head_inc;
                                    held_next = held_reg - CNT_W'(1);
                                end
                            end
                            ok_c = (req.cmd == CMD_ALIGN) ? 1'b1 : adv_fit;
                        end
                        CMD_FLUSH:
                        begin
                            head_next = '0;
                            held_next = '0;
                            pos_next  = '0;
                            ok_c      = 1'b1;
                        end
                        default:
                        begin
                            ok_c = 1'b0;
                        end
                    endcase
                    if (req.cmd != CMD_PEEK)
                    begin
                        out_valid_next = 1'b1;
                        value_next     = '0;
                        ok_next        = ok_c;
                        fill_next      = fill_t'(held_next);
                    end
                end
            end
            ST_PEEK:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                value_next     = peek_ok ? peek_bits : '0;
                ok_next        = peek_ok;
                fill_next      = fill_t'(held_reg);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        value_reg <= value_next;
        ok_reg    <= ok_next;
        fill_reg  <= fill_next;
    end

endmodule
`default_nettype wire

// ===== sv/qfbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module qfbr_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench: checks the quadword bit reader's reply words against a predictor of its own.
`timescale 1ns / 1ps
module testbench;
    import qfbr_pkg::*;

    // Run shape
    localparam int QUAD_BITS    = 128;
    localparam int RANDOM_WORDS = 1400;
    localparam int HOLD_AFTER   = 600;   // command words taken before the long reply hold-off
    localparam int HOLD_CYCLES  = 400;   // length of that hold-off
    localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either channel
    localparam int TAIL_CYCLES  = 8;     // longer than a peek takes, so this is ample

    // Codes past flush are not decoded by the block
    localparam cmd_t CMD_UNUSED_LO = CMD_FLUSH + 3'd1;
    localparam cmd_t CMD_UNUSED_HI = '1;

    typedef struct packed {
        cmd_t   cmd;
        half_t  upper;
        half_t  lower;
        count_t count;
        adv_t   adv;
    } cmd_word_t;

    typedef struct packed {
        value_t value;
        logic   ok;
        fill_t  fill;
    } reply_word_t;

    // One row of the directed table: the word and, where obvious, its reply typed in
    typedef struct packed {
        cmd_word_t   word;
        logic        typed;
        reply_word_t reply;
    } dir_row_t;

    // One outstanding reply: what the predictor worked out, plus any typed-in value
    typedef struct packed {
        reply_word_t pred;
        logic        typed;
        reply_word_t typed_reply;
    } due_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    qfbr_in_if  req_if ();
    qfbr_out_if rsp_if ();

    quadword_fifo_bit_reader_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Side-band tag carried alongside each command word so that the monitor
    // knows whether a typed-in reply goes with it.
    logic        word_typed;
    reply_word_t word_typed_reply;

    // ------------------------------------------------------------------
    // Predictor state: a copy of the quadword FIFO and the read pointer.
    // Each slot holds {upper, lower}; stream byte k is bits 8k+7:8k, MSB first.
    // ------------------------------------------------------------------
    logic [127:0]      pq_store [FIFO_DEPTH];
    logic [SLOT_W-1:0] pq_head = '0;
    logic [CNT_W-1:0]  pq_held = '0;
    logic [POS_W-1:0]  pq_pos  = '0;

    due_t     replies_due [$];
    dir_row_t dir_rows [$];

    int fault_count  = 0;
    int words_in     = 0;
    int replies_seen = 0;
    int quiet_cycles = 0;
    int cmd_tally  [8];
    int fail_tally [8];

    cmd_word_t   mon_word;
    reply_word_t mon_got;
    due_t        mon_due;

    // Consume up to 32 bits; refused whole if it would run past the held data.
    // Whenever the pointer crosses a quadword boundary the head slot is retired.
    function automatic logic consume_bits(input int unsigned amount);
        int pos;
        if (amount > MAX_BITS)
            amount = MAX_BITS;
        pos = int'(pq_pos) + int'(amount);
        if (pos > int'(pq_held) * QUAD_BITS)
            return 1'b0;
        while (pos >= QUAD_BITS && pq_held != 0)
        begin
            pos     -= QUAD_BITS;
            pq_head = SLOT_W'((int'(pq_head) + 1) % FIFO_DEPTH);
            pq_held = pq_held - 1'b1;
        end
        pq_pos = POS_W'(pos);
        return 1'b1;
    endfunction

    // Bit at a stream offset counted from the start of the head quadword
    function automatic logic stream_bit(input int off);
        int quad_off;
        int slot;
        quad_off = off % QUAD_BITS;
        slot     = (int'(pq_head) + off / QUAD_BITS) % FIFO_DEPTH;
        return pq_store[slot][(quad_off / 8) * 8 + 7 - quad_off % 8];
    endfunction

    function automatic reply_word_t bitstream_predict(input cmd_word_t w);
        reply_word_t r;
        int          left;
        int          slot;
        r = '0;
        case (w.cmd)
            CMD_PUSH:
            begin
                // a full FIFO drops the quadword
                if (pq_held < FIFO_DEPTH)
                begin
                    slot           = (int'(pq_head) + int'(pq_held)) % FIFO_DEPTH;
                    pq_store[slot] = {w.upper, w.lower};
                    pq_held        = pq_held + 1'b1;
                    r.ok           = 1'b1;
                end
            end
            CMD_PEEK:
            begin
                // bad count, nothing left or too few bits: value stays zero
                left = int'(pq_held) * QUAD_BITS - int'(pq_pos);
                if (w.count >= 1 && w.count <= MAX_BITS && left != 0 && left >= int'(w.count))
                begin
                    for (int i = 0; i < int'(w.count); i++)
                        r.value = {r.value[30:0], stream_bit(int'(pq_pos) + i)};
                    r.ok = 1'b1;
                end
            end
            CMD_ADVANCE:
                r.ok = consume_bits(w.adv);
            CMD_ALIGN:
            begin
                // may fail silently at the end of data, still reports success
                if (pq_pos[2:0] != 3'd0)
                    void'(consume_bits(8 - pq_pos[2:0]));
                r.ok = 1'b1;
            end
            CMD_FLUSH:
            begin
                pq_head = '0;
                pq_held = '0;
                pq_pos  = '0;
                r.ok    = 1'b1;
            end
            default:
                ;
        endcase
        r.fill = fill_t'(pq_held);
        return r;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_reply(input reply_word_t want, input reply_word_t got,
                               input string src);
        if (got.value !== want.value || got.ok !== want.ok || got.fill !== want.fill)
            report_fault($sformatf(
                "reply %0d (%s) value %h/%h ok %b/%b fill %0d/%0d (exp/got)",
                replies_seen, src, want.value, got.value, want.ok, got.ok,
                want.fill, got.fill));
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random command word. push_w steers the mix between filling and draining.
    function automatic cmd_word_t random_word(input int push_w);
        cmd_word_t w;
        int        r;
        w.upper = {$urandom, $urandom};
        w.lower = {$urandom, $urandom};
        // odd counts and oversize advances now and then, the rest well formed
        w.count = ($urandom_range(0, 9) == 0) ? count_t'($urandom_range(0, 63))
                                              : count_t'($urandom_range(1, MAX_BITS));
        w.adv   = ($urandom_range(0, 4) == 0) ? adv_t'($urandom_range(0, 255))
                                              : adv_t'($urandom_range(0, MAX_BITS));
        r = $urandom_range(0, 99);
        if (r < 2)
            w.cmd = cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (r < 3)
            w.cmd = CMD_FLUSH;
        else if (r < 3 + push_w)
            w.cmd = CMD_PUSH;
        else if (r < 60)
            w.cmd = CMD_PEEK;
        else if (r < 90)
            w.cmd = CMD_ADVANCE;
        else
            w.cmd = CMD_ALIGN;
        return w;
    endfunction

    function automatic void add_row(input cmd_t c, input half_t up, input half_t lo,
                                    input count_t n, input adv_t a, input logic typed,
                                    input value_t v, input logic ok, input fill_t f);
        dir_row_t row;
        row.word  = '{cmd: c, upper: up, lower: lo, count: n, adv: a};
        row.typed = typed;
        row.reply = '{value: v, ok: ok, fill: f};
        dir_rows.push_back(row);
    endfunction

    // Offer one word after an optional gap and hold it until the block takes it.
    // valid is only lowered when a gap comes, so it never toggles within a step.
    task automatic offer_word(input cmd_word_t w, input logic typed,
                              input reply_word_t want, input int gap);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= w.cmd;
        req_if.push_upper <= w.upper;
        req_if.push_lower <= w.lower;
        req_if.bit_count  <= w.count;
        req_if.advance_by <= w.adv;
        word_typed        <= typed;
        word_typed_reply  <= want;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Monitor: replies are checked first, then the accepted command word is
    // run through the predictor. Both sample pre-edge values at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                mon_got = {rsp_if.peek_value, rsp_if.ok, rsp_if.fill_level};
                if (replies_due.size() == 0)
                    report_fault($sformatf("reply %0d with nothing outstanding: %h %b %0d",
                                           replies_seen, mon_got.value, mon_got.ok,
                                           mon_got.fill));
                else
                begin
                    mon_due = replies_due[0];
                    replies_due.delete(0);
                    check_reply(mon_due.pred, mon_got, "predicted");
                    if (mon_due.typed)
                        check_reply(mon_due.typed_reply, mon_got, "directed");
                end
                replies_seen++;
            end
            if (req_if.valid && req_if.ready)
            begin
                mon_word = {req_if.cmd, req_if.push_upper, req_if.push_lower,
                            req_if.bit_count, req_if.advance_by};
                mon_due.pred        = bitstream_predict(mon_word);
                mon_due.typed       = word_typed;
                mon_due.typed_reply = word_typed_reply;
                replies_due.push_back(mon_due);
                cmd_tally[mon_word.cmd]++;
                if (!mon_due.pred.ok)
                    fail_tally[mon_word.cmd]++;
                words_in++;
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d replies outstanding",
                         quiet_cycles, replies_due.size());
                $display("quadword_fifo_bit_reader_core verification failed");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Reply side: random ready with stretches of steady acceptance, plus one
    // long hold-off mid-run so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial
    begin : reply_sink
        int   gap;
        int   burst;
        logic held_off;
        held_off = 1'b0;
        rsp_if.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = idle_gap();
            if (!held_off && words_in >= HOLD_AFTER)
            begin
                gap      = HOLD_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 12);
            repeat (burst) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Command side: reset, directed table, random phases, then drain.
    // ------------------------------------------------------------------
    initial
    begin : cmd_source
        logic filling;
        logic calm;
        int   push_w;
        int   phase_left;
        int   unknown_words;
        int   unknown_fails;

        req_if.valid      <= 1'b0;
        req_if.cmd        <= CMD_PUSH;
        req_if.push_upper <= '0;
        req_if.push_lower <= '0;
        req_if.bit_count  <= '0;
        req_if.advance_by <= '0;
        word_typed        <= 1'b0;
        word_typed_reply  <= '0;
        foreach (cmd_tally[k])
        begin
            cmd_tally[k]  = 0;
            fail_tally[k] = 0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty reader: peek and over-advance refused, zero advance and align fine
        add_row(CMD_PEEK,    '0, '0, 6'd1,  8'd0,   1'b1, 32'h0, 1'b0, 4'd0);
        add_row(CMD_ADVANCE, '0, '0, 6'd1,  8'd0,   1'b1, 32'h0, 1'b1, 4'd0);
        add_row(CMD_ADVANCE, '0, '0, 6'd1,  8'd1,   1'b1, 32'h0, 1'b0, 4'd0);
        add_row(CMD_ALIGN,   '0, '0, 6'd1,  8'd0,   1'b1, 32'h0, 1'b1, 4'd0);
        // All ones, all zeros and a byte-order pattern
        add_row(CMD_PUSH,    '1, '1, 6'd0,  8'd0,   1'b1, 32'h0, 1'b1, 4'd1);
        add_row(CMD_PEEK,    '0, '0, 6'd32, 8'd0,   1'b1, '1,    1'b1, 4'd1);
        add_row(CMD_PUSH,    '0, '0, 6'd0,  8'd0,   1'b1, 32'h0, 1'b1, 4'd2);
        add_row(CMD_PUSH, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 6'd0, 8'd0,
                1'b1, 32'h0, 1'b1, 4'd3);
        // Peek counts out of range
        add_row(CMD_PEEK,    '0, '0, 6'd0,  8'd0,   1'b1, 32'h0, 1'b0, 4'd3);
        add_row(CMD_PEEK,    '0, '0, 6'd33, 8'd0,   1'b1, 32'h0, 1'b0, 4'd3);
        // Oversize advances clamp to 32; walk the pointer to three bits short
        add_row(CMD_ADVANCE, '0, '0, 6'd0,  8'd255, 1'b1, 32'h0, 1'b1, 4'd3);
        add_row(CMD_ADVANCE, '0, '0, 6'd0,  8'd93,  1'b0, '0,    1'b0, '0);
        add_row(CMD_ADVANCE, '0, '0, 6'd0,  8'd32,  1'b0, '0,    1'b0, '0);
        add_row(CMD_ADVANCE, '0, '0, 6'd0,  8'd29,  1'b0, '0,    1'b0, '0);
        // Peek across the quadword boundary, then align over it to retire the head
        add_row(CMD_PEEK,    '0, '0, 6'd32, 8'd0,   1'b0, '0,    1'b0, '0);
        add_row(CMD_ALIGN,   '0, '0, 6'd0,  8'd0,   1'b0, '0,    1'b0, '0);
        add_row(CMD_UNUSED_LO, '0, '0, 6'd5, 8'd5,  1'b1, 32'h0, 1'b0, 4'd2);
        // Fill up, push once more into a full FIFO, then flush
        for (int k = 0; k < 6; k++)
            add_row(CMD_PUSH, {16{4'(k + 3)}}, ~{16{4'(k + 3)}}, 6'd0, 8'd0,
                    1'b0, '0, 1'b0, '0);
        add_row(CMD_PUSH,    '1, '0, 6'd0,  8'd0,   1'b1, 32'h0, 1'b0, 4'd8);
        add_row(CMD_FLUSH,   '0, '0, 6'd0,  8'd0,   1'b1, 32'h0, 1'b1, 4'd0);

        foreach (dir_rows[k])
            offer_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].reply, idle_gap());

        // Random part in phases that alternately fill and drain the FIFO,
        // some of them with no gaps at all
        filling    = 1'b0;
        phase_left = 0;
        push_w     = 3;
        calm       = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                push_w     = filling ? 20 : 3;
                calm       = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(60, 160);
            end
            phase_left--;
            offer_word(random_word(push_w), 1'b0, '0, calm ? 0 : idle_gap());
        end
        req_if.valid <= 1'b0;

        // One more edge so the monitor has logged the last word, then drain
        // and give the block time to show any stray reply
        @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        unknown_words = 0;
        unknown_fails = 0;
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
        begin
            unknown_words += cmd_tally[c];
            unknown_fails += fail_tally[c];
        end
        $display("Covered %0d command words: %0d push (%0d refused), %0d peek (%0d refused),",
                 words_in, cmd_tally[CMD_PUSH], fail_tally[CMD_PUSH],
                 cmd_tally[CMD_PEEK], fail_tally[CMD_PEEK]);
        $display("  %0d advance (%0d refused), %0d align, %0d flush, %0d unknown; %0d replies",
                 cmd_tally[CMD_ADVANCE], fail_tally[CMD_ADVANCE], cmd_tally[CMD_ALIGN],
                 cmd_tally[CMD_FLUSH], unknown_words, replies_seen);
        if (fault_count == 0)
            $display("quadword_fifo_bit_reader_core verification clean");
        else
        begin
            $display("%0d mismatches in total", fault_count);
            $display("quadword_fifo_bit_reader_core verification failed");
        end
        $finish;
    end

endmodule

// ===== quadword_fifo_bit_reader_core.f =====
sv/qfbr_pkg.sv
sv/qfbr_in_if.sv
sv/qfbr_out_if.sv
sv/qfbr_ram.sv
sv/quadword_fifo_bit_reader_core.sv
tb/sv/testbench.sv
